[rtl/core/trc_pkg.sv]
`timescale 1ns / 1ps

package trc_pkg;

  // Rotor geometry
  localparam int unsigned ROTOR_SIZE_DEF = 28;
  localparam int unsigned SLOT_W         = 6;   // holds any position of the largest rotor (64)
  localparam int unsigned VAL_W          = 5;
  localparam int unsigned CHAR_W         = 8;
  localparam int unsigned QUEUE_DEPTH    = 2;

  // Character codes
  localparam logic [CHAR_W-1:0] CHR_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CHR_SPACE   = 8'd32;
  localparam logic [CHAR_W-1:0] CHR_PERIOD  = 8'd46;
  localparam logic [CHAR_W-1:0] CHR_UPPER_A = 8'd65;
  localparam logic [CHAR_W-1:0] CHR_UPPER_Z = 8'd90;
  localparam logic [CHAR_W-1:0] CHR_LOWER_A = 8'd97;
  localparam logic [CHAR_W-1:0] CHR_LOWER_Z = 8'd122;
  localparam logic [CHAR_W-1:0] CASE_GAP    = 8'd32;
  localparam logic [CHAR_W-1:0] SYM_SPACE   = 8'd26;
  localparam logic [CHAR_W-1:0] SYM_PERIOD  = 8'd27;

  typedef enum logic [1:0] {
    MODE_LOAD = 2'd0,
    MODE_ENC  = 2'd1,
    MODE_DEC  = 2'd2,
    MODE_TURN = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_TURN,
    OP_ECHO,
    OP_ENC,
    OP_DEC
  } op_e;

  typedef enum logic {
    BK_READY,
    BK_MATCH
  } bk_state_e;

  // Classified request handed from front to back
  typedef struct packed {
    op_e               op;
    logic              sel;
    logic [SLOT_W-1:0] slot;   // load position, turn amount or symbol index
    logic [VAL_W-1:0]  value;
    logic [CHAR_W-1:0] ch;
    logic              bad;
  } cmd_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_out;
    logic              bad_char;
  } res_t;

endpackage

[rtl/core/trc_queue.sv]
`timescale 1ns / 1ps

module trc_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = trc_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);
  import trc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[rtl/core/trc_front.sv]
`timescale 1ns / 1ps

module trc_front #(
  parameter int unsigned ROTOR_SIZE = trc_pkg::ROTOR_SIZE_DEF
) (
  input  logic                        push_i,
  input  logic [1:0]                  mode_i,
  input  logic                        rotor_sel_i,
  input  logic [4:0]                  entry_index_i,
  input  logic [trc_pkg::VAL_W-1:0]   entry_value_i,
  input  logic [trc_pkg::CHAR_W-1:0]  char_in_i,
  input  logic [7:0]                  turns_i,
  input  logic                        cmd_full_i,
  output logic                        cmd_push_o,
  output trc_pkg::cmd_t               cmd_o
);
  import trc_pkg::*;

  localparam logic [7:0]  NMOD  = 8'(ROTOR_SIZE);
  localparam logic [15:0] RECIP = 16'((65536 + ROTOR_SIZE - 1) / ROTOR_SIZE);

  // Reciprocal multiply gives the exact quotient for any 8-bit amount
  function automatic logic [7:0] mod_size(input logic [7:0] v);
    logic [23:0] prod;
    logic [7:0]  quo;
    logic [15:0] back;
    prod = {16'd0, v} * {8'd0, RECIP};
    quo  = prod[23:16];
    back = {8'd0, quo} * {8'd0, NMOD};
    return v - back[7:0];
  endfunction

  logic [CHAR_W-1:0] upper, sym;
  logic              sym_ok, keep;

  always_comb begin
    upper = char_in_i;
    if (char_in_i >= CHR_LOWER_A && char_in_i <= CHR_LOWER_Z) begin
      upper = char_in_i - CASE_GAP;
    end
    sym_ok = 1'b1;
    sym    = '0;
    if (upper == CHR_SPACE) begin
      sym = SYM_SPACE;
    end else if (upper == CHR_PERIOD) begin
      sym = SYM_PERIOD;
    end else if (upper >= CHR_UPPER_A && upper <= CHR_UPPER_Z) begin
      sym = upper - CHR_UPPER_A;
    end else begin
      sym_ok = 1'b0;
    end
    if (sym >= NMOD) begin
      sym_ok = 1'b0;
    end
  end

  always_comb begin
    keep        = 1'b1;
    cmd_o.op    = OP_ECHO;
    cmd_o.sel   = rotor_sel_i;
    cmd_o.slot  = '0;
    cmd_o.value = entry_value_i;
    cmd_o.ch    = char_in_i;
    cmd_o.bad   = 1'b0;
    unique case (mode_e'(mode_i))
      MODE_LOAD: begin
        cmd_o.op   = OP_LOAD;
        cmd_o.slot = SLOT_W'(entry_index_i);
        // drop loads past the end of the rotor
        keep       = (8'(entry_index_i) < NMOD);
      end
      MODE_TURN: begin
        cmd_o.op   = OP_TURN;
        cmd_o.slot = SLOT_W'(mod_size(turns_i));
      end
      MODE_ENC, MODE_DEC: begin
        if (char_in_i == CHR_NEWLINE) begin
          cmd_o.op = OP_ECHO;
        end else if (!sym_ok) begin
          cmd_o.op  = OP_ECHO;
          cmd_o.bad = 1'b1;
        end else begin
          cmd_o.op   = (mode_e'(mode_i) == MODE_ENC) ? OP_ENC : OP_DEC;
          cmd_o.slot = SLOT_W'(sym);
        end
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign cmd_push_o = push_i && !cmd_full_i && keep;

endmodule

[rtl/core/trc_back.sv]
`timescale 1ns / 1ps

module trc_back #(
  parameter int unsigned ROTOR_SIZE = trc_pkg::ROTOR_SIZE_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_empty_i,
  input  trc_pkg::cmd_t  cmd_i,
  output logic           cmd_pop_o,
  input  logic           res_full_i,
  output logic           res_push_o,
  output trc_pkg::res_t  res_o
);
  import trc_pkg::*;

  localparam int unsigned IW = (ROTOR_SIZE > 1) ? $clog2(ROTOR_SIZE) : 1;
  localparam int unsigned PW = $clog2(ROTOR_SIZE + 1);
  localparam logic [IW:0] NSZ = (IW + 1)'(ROTOR_SIZE);

  function automatic logic [IW-1:0] wrap(input logic [IW:0] s);
    logic [IW:0] t;
    t = (s >= NSZ) ? s - NSZ : s;
    return t[IW-1:0];
  endfunction

  function automatic logic [IW-1:0] phys_one(input logic [IW-1:0] k, input logic [IW-1:0] off);
    return wrap({1'b0, k} + (NSZ - {1'b0, off}));
  endfunction

  function automatic logic [IW-1:0] phys_two(input logic [IW-1:0] k, input logic [IW-1:0] off);
    return wrap({1'b0, k} + {1'b0, off});
  endfunction

  logic [VAL_W-1:0]      rotor_one_q [ROTOR_SIZE];
  logic [VAL_W-1:0]      rotor_two_q [ROTOR_SIZE];
  logic [IW-1:0]         off_one_q, off_one_d, off_two_q, off_two_d;
  logic [ROTOR_SIZE-1:0] match_q, match_d, seen;
  bk_state_e             state_q, state_d;
  logic [IW-1:0]         slot, key_addr, load_addr;
  logic [VAL_W-1:0]      key;
  logic [PW-1:0]         pos;
  logic [CHAR_W-1:0]     pos_byte, cipher_char;
  logic                  is_enc, load_we;

  assign slot   = cmd_i.slot[IW-1:0];
  assign is_enc = (cmd_i.op == OP_ENC);

  // Step one: fetch the key and compare it against every entry of the other rotor
  always_comb begin
    key_addr = is_enc ? phys_one(slot, off_one_q) : phys_two(slot, off_two_q);
    key      = is_enc ? rotor_one_q[key_addr] : rotor_two_q[key_addr];
    for (int j = 0; j < ROTOR_SIZE; j++) begin
      match_d[j] = ((is_enc ? rotor_two_q[j] : rotor_one_q[j]) == key);
    end
  end

  // Step two: put hits in seen order and take the first one
  always_comb begin
    for (int p = 0; p < ROTOR_SIZE; p++) begin
      seen[p] = match_q[is_enc ? phys_two(IW'(p), off_two_q) : phys_one(IW'(p), off_one_q)];
    end
    pos = PW'(ROTOR_SIZE);
    for (int p = ROTOR_SIZE - 1; p >= 0; p--) begin
      if (seen[p]) begin
        pos = PW'(p);
      end
    end
    pos_byte = CHAR_W'(pos);
    if (pos_byte == SYM_SPACE) begin
      cipher_char = CHR_SPACE;
    end else if (pos_byte == SYM_PERIOD) begin
      cipher_char = CHR_PERIOD;
    end else begin
      cipher_char = pos_byte + CHR_UPPER_A;
    end
  end

  assign load_addr = cmd_i.sel ? phys_two(slot, off_two_q) : phys_one(slot, off_one_q);

  always_comb begin
    state_d        = state_q;
    cmd_pop_o      = 1'b0;
    res_push_o     = 1'b0;
    res_o.char_out = cmd_i.ch;
    res_o.bad_char = cmd_i.bad;
    load_we        = 1'b0;
    off_one_d      = off_one_q;
    off_two_d      = off_two_q;
    unique case (state_q)
      BK_READY: begin
        if (!cmd_empty_i) begin
          unique case (cmd_i.op) inside
            OP_LOAD: begin
              load_we   = 1'b1;
              cmd_pop_o = 1'b1;
            end
            OP_TURN: begin
              cmd_pop_o = 1'b1;
              if (cmd_i.sel) begin
                off_two_d = wrap({1'b0, off_two_q} + {1'b0, slot});
              end else begin
                off_one_d = wrap({1'b0, off_one_q} + {1'b0, slot});
              end
            end
            OP_ECHO: begin
              if (!res_full_i) begin
                res_push_o = 1'b1;
                cmd_pop_o  = 1'b1;
              end
            end
            OP_ENC, OP_DEC: begin
              // hold the request at the head until the result goes out
              if (!res_full_i) begin
                state_d = BK_MATCH;
              end
            end
            default: begin
              cmd_pop_o = 1'b1;
            end
          endcase
        end
      end
      BK_MATCH: begin
        res_push_o     = 1'b1;
        cmd_pop_o      = 1'b1;
        res_o.char_out = cipher_char;
        res_o.bad_char = 1'b0;
        off_one_d      = wrap({1'b0, off_one_q} + (IW + 1)'(1));
        off_two_d      = wrap({1'b0, off_two_q} + (IW + 1)'(1));
        state_d        = BK_READY;
      end
      default: begin
        state_d = BK_READY;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_READY;
      off_one_q <= '0;
      off_two_q <= '0;
    end else begin
      state_q   <= state_d;
      off_one_q <= off_one_d;
      off_two_q <= off_two_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == BK_READY && state_d == BK_MATCH) begin
      match_q <= match_d;
    end
    if (load_we) begin
      if (cmd_i.sel) begin
        rotor_two_q[load_addr] <= cmd_i.value;
      end else begin
        rotor_one_q[load_addr] <= cmd_i.value;
      end
    end
  end

endmodule

[rtl/core/two_rotor_substitution_cipher.sv]
`timescale 1ns / 1ps
// Two-rotor substitution cipher over a 28-symbol alphabet (A-Z, space, period).
// Input channel: a queue write port. Present mode_i and its fields with push high;
// the request is taken on a rising edge where push is high and full is low.
// Modes: load one rotor entry, encrypt a byte, decrypt a byte, turn a rotor.
// Result channel: a queue read port. While empty is low the oldest result sits on
// char_out_o / bad_char_o; raise pop to take it. Only encrypt and decrypt requests
// produce a result; loads and turns complete silently.
// An echoed byte (newline or one outside the alphabet) goes to the result queue,
// and a load or turn is applied, straight from the ready state. An enciphered byte
// first reads the key and compares it against every entry of the other rotor,
// registering the hits, then in the match state rotates the hits into seen order
// and priority-encodes the first one.
// A two-entry request queue sits between the classifier and the back end, and a
// two-entry result queue sits at the output, so requests keep being taken while
// a result waits. When the receiver stalls the result queue fills, the back end
// holds, then the request queue fills and full rises.
// Reset clears both rotor offsets and both queues; rotor contents are undefined
// until loaded.
module two_rotor_substitution_cipher #(
  parameter int unsigned ROTOR_SIZE = trc_pkg::ROTOR_SIZE_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [1:0]                  mode_i,
  input  logic                        rotor_sel_i,
  input  logic [4:0]                  entry_index_i,
  input  logic [trc_pkg::VAL_W-1:0]   entry_value_i,
  input  logic [trc_pkg::CHAR_W-1:0]  char_in_i,
  input  logic [7:0]                  turns_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [trc_pkg::CHAR_W-1:0]  char_out_o,
  output logic                        bad_char_o
);
  import trc_pkg::*;

  localparam int unsigned CmdW = $bits(cmd_t);
  localparam int unsigned ResW = $bits(res_t);

  cmd_t            cmd_wr, cmd_head;
  res_t            res_wr, res_head;
  logic [CmdW-1:0] cmd_rd_raw;
  logic [ResW-1:0] res_rd_raw;
  logic            cmd_push, cmd_full, cmd_empty, cmd_pop;
  logic            res_push, res_full;

  // Classify incoming requests
  trc_front #(
    .ROTOR_SIZE(ROTOR_SIZE)
  ) u_front (
    .push_i       (push),
    .mode_i       (mode_i),
    .rotor_sel_i  (rotor_sel_i),
    .entry_index_i(entry_index_i),
    .entry_value_i(entry_value_i),
    .char_in_i    (char_in_i),
    .turns_i      (turns_i),
    .cmd_full_i   (cmd_full),
    .cmd_push_o   (cmd_push),
    .cmd_o        (cmd_wr)
  );

  trc_queue #(
    .Width(CmdW),
    .Depth(QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .data_i (cmd_wr),
    .full_o (cmd_full),
    .pop_i  (cmd_pop),
    .data_o (cmd_rd_raw),
    .empty_o(cmd_empty)
  );

  assign cmd_head = cmd_t'(cmd_rd_raw);
  assign full     = cmd_full;

  // Execute against the rotors
  trc_back #(
    .ROTOR_SIZE(ROTOR_SIZE)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_empty_i(cmd_empty),
    .cmd_i      (cmd_head),
    .cmd_pop_o  (cmd_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res_wr)
  );

  trc_queue #(
    .Width(ResW),
    .Depth(QUEUE_DEPTH)
  ) u_res_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_wr),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (res_rd_raw),
    .empty_o(empty)
  );

  assign res_head   = res_t'(res_rd_raw);
  assign char_out_o = res_head.char_out;
  assign bad_char_o = res_head.bad_char;

  // The back end never writes a result into a full output queue
  a_res_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full)
    else $error("result written while result queue full");

  // Requests leave the queue only when one is there
  a_cmd_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> !cmd_empty)
    else $error("request popped from empty queue");

  // Every result retires the request that caused it in the same cycle
  a_res_retires_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> cmd_pop)
    else $error("result written without retiring its request");

endmodule
